@@ design/i2cee_pkg.sv @@
// Package for the I2C EEPROM byte access master: sequencer phase codes,
// request kinds, register indexes, state and result types, helper functions.
// No dependencies.
`timescale 1ns / 1ps

package i2cee_pkg;

    // Width of the per-phase tick down-counter
    localparam int DLY_W = 8;
    localparam int DMAX  = (1 << DLY_W) - 1;

    // Request kinds on the input channel
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes
    localparam logic REG_BYTE_TICKS  = 1'b0;
    localparam logic REG_FRAME_TICKS = 1'b1;

    localparam logic [7:0] BYTE_TICKS_RST  = 8'd10;
    localparam logic [7:0] FRAME_TICKS_RST = 8'd20;

    // Sequencer phases
    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_ST_A      = 5'd1;
    localparam logic [4:0] PH_ST_B      = 5'd2;
    localparam logic [4:0] PH_ST_C      = 5'd3;
    localparam logic [4:0] PH_ST_D      = 5'd4;
    localparam logic [4:0] PH_BIT_SET   = 5'd5;
    localparam logic [4:0] PH_BIT_HIGH  = 5'd6;
    localparam logic [4:0] PH_BIT_LOW   = 5'd7;
    localparam logic [4:0] PH_ACK_REL   = 5'd8;
    localparam logic [4:0] PH_ACK_HIGH  = 5'd9;
    localparam logic [4:0] PH_ACK_LOW   = 5'd10;
    localparam logic [4:0] PH_ACK_DRIVE = 5'd11;
    localparam logic [4:0] PH_RD_HIGH   = 5'd12;
    localparam logic [4:0] PH_RD_HOLD   = 5'd13;
    localparam logic [4:0] PH_RD_LOW    = 5'd14;
    localparam logic [4:0] PH_NK_DRIVE  = 5'd15;
    localparam logic [4:0] PH_NK_SDA    = 5'd16;
    localparam logic [4:0] PH_NK_HIGH   = 5'd17;
    localparam logic [4:0] PH_NK_LOW    = 5'd18;
    localparam logic [4:0] PH_SP_HIGH   = 5'd19;
    localparam logic [4:0] PH_SP_SDA    = 5'd20;

    // Byte slots of a transaction
    localparam logic [2:0] BYTE_DEV   = 3'd0;
    localparam logic [2:0] BYTE_AHI   = 3'd1;
    localparam logic [2:0] BYTE_ALO   = 3'd2;
    localparam logic [2:0] BYTE_DATA  = 3'd3;
    localparam logic [2:0] BYTE_RDDEV = 3'd4;

    typedef struct packed {
        logic       is_read;
        logic [6:0] dev_addr;
        logic [7:0] addr_high;
        logic [7:0] addr_low;
        logic [7:0] write_value;
        logic [6:0] rd_dev_addr;
    } t_req;

    typedef struct packed {
        logic [4:0]       phase;
        logic [3:0]       bit_cnt;
        logic [2:0]       byte_idx;
        logic [7:0]       shreg;
        logic [DLY_W-1:0] dly;
        logic [7:0]       rx;
        t_req             req;
        logic             scl;
        logic             sda;
        logic             rel;
    } t_state;

    typedef struct packed {
        logic done;
        logic rejected;
    } t_flags;

    // Phase length from a register: zero lasts one tick, clamp to the counter
    function automatic logic [DLY_W-1:0] load_ticks(input logic [7:0] r);
        logic [15:0] v;
        v = {8'd0, r};
        if (v == 16'd0) v = 16'd1;
        if (v > DMAX) v = 16'(DMAX);
        return v[DLY_W-1:0];
    endfunction

    function automatic logic [7:0] byte_value(input t_req q, input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            BYTE_DEV:  b = {q.dev_addr, 1'b0};
            BYTE_AHI:  b = q.addr_high;
            BYTE_ALO:  b = q.addr_low;
            BYTE_DATA: b = q.write_value;
            default:   b = {q.rd_dev_addr, 1'b1};
        endcase
        return b;
    endfunction

endpackage

@@ design/i2cee_step.sv @@
// Next-state logic of the I2C pin sequencer: one item (tick or request)
// applied to the current state. Combinational only; uses i2cee_pkg.
`timescale 1ns / 1ps

module i2cee_step (
    input  i2cee_pkg::t_state i_state,
    input  i2cee_pkg::t_req   i_req,
    input  logic [1:0]        i_kind,
    input  logic              i_sda,
    input  logic [7:0]        i_byte_ticks,
    input  logic [7:0]        i_frame_ticks,
    output i2cee_pkg::t_state o_state,
    output i2cee_pkg::t_flags o_flags
);
    import i2cee_pkg::*;

    always_comb begin
        t_state           s;
        logic [4:0]       p;
        logic             do_enter;
        logic             frame;
        logic             was_stop;
        logic             busy;
        logic [DLY_W-1:0] d;

        s        = i_state;
        p        = s.phase;
        do_enter = 1'b0;
        frame    = 1'b1;
        was_stop = 1'b0;
        d        = s.dly;
        busy     = (s.phase != PH_IDLE);
        o_flags  = '0;

        if (i_kind == KIND_WRITE || i_kind == KIND_READ) begin
            if (busy) begin
                o_flags.rejected = 1'b1;
            end else begin
                s.req      = i_req;
                s.byte_idx = BYTE_DEV;
                s.bit_cnt  = 4'd0;
                s.shreg    = 8'd0;
                p          = PH_ST_A;
                do_enter   = 1'b1;
            end
        end else if (busy) begin
            if (s.dly != '0) d = s.dly - DLY_W'(1);
            s.dly = d;
            if (d == '0) begin
                was_stop = (s.phase == PH_SP_SDA);
                unique case (s.phase)
                    PH_ST_A, PH_ST_B, PH_ST_C, PH_BIT_SET, PH_BIT_HIGH,
                    PH_ACK_REL, PH_ACK_HIGH, PH_ACK_LOW, PH_RD_HIGH, PH_RD_HOLD,
                    PH_NK_DRIVE, PH_NK_SDA, PH_NK_HIGH, PH_SP_HIGH: begin
                        p = s.phase + 5'd1;
                    end
                    PH_ST_D: begin
                        s.shreg   = byte_value(s.req, s.byte_idx);
                        s.bit_cnt = 4'd0;
                        p         = PH_BIT_SET;
                    end
                    PH_BIT_LOW: begin
                        s.bit_cnt = s.bit_cnt + 4'd1;
                        p = (s.bit_cnt < 4'd8) ? PH_BIT_SET : PH_ACK_REL;
                    end
                    PH_ACK_DRIVE: begin
                        unique case (s.byte_idx)
                            BYTE_DEV, BYTE_AHI: begin
                                s.byte_idx = s.byte_idx + 3'd1;
                                s.shreg    = byte_value(s.req, s.byte_idx);
                                s.bit_cnt  = 4'd0;
                                p          = PH_BIT_SET;
                            end
                            BYTE_ALO: begin
                                if (s.req.is_read) begin
                                    s.byte_idx = BYTE_RDDEV;
                                    p          = PH_ST_A;
                                end else begin
                                    s.byte_idx = BYTE_DATA;
                                    s.shreg    = byte_value(s.req, BYTE_DATA);
                                    s.bit_cnt  = 4'd0;
                                    p          = PH_BIT_SET;
                                end
                            end
                            BYTE_RDDEV: begin
                                s.bit_cnt = 4'd0;
                                s.shreg   = 8'd0;
                                p         = PH_RD_HIGH;
                            end
                            default: p = PH_SP_HIGH;
                        endcase
                    end
                    PH_RD_LOW: p = (s.bit_cnt < 4'd8) ? PH_RD_HIGH : PH_NK_DRIVE;
                    PH_NK_LOW: p = PH_SP_HIGH;
                    default:   p = PH_IDLE;
                endcase
                if (p == PH_IDLE) begin
                    s.dly         = '0;
                    o_flags.done  = was_stop;
                end else begin
                    do_enter = 1'b1;
                end
            end
        end

        s.phase = p;

        // Pin actions on entry to a phase, then reload the phase timer
        if (do_enter) begin
            unique case (p)
                PH_ST_A:     begin s.rel = 1'b0; s.sda = 1'b1; end
                PH_ST_B:     s.scl = 1'b1;
                PH_ST_C:     s.sda = 1'b0;
                PH_ST_D:     s.scl = 1'b0;
                PH_BIT_SET:  begin s.sda = s.shreg[~s.bit_cnt[2:0]]; frame = 1'b0; end
                PH_BIT_HIGH: begin s.scl = 1'b1; frame = 1'b0; end
                PH_BIT_LOW:  begin s.scl = 1'b0; frame = 1'b0; end
                PH_ACK_REL: begin
                    if (s.byte_idx == BYTE_DEV || s.byte_idx == BYTE_DATA ||
                        s.byte_idx == BYTE_RDDEV) s.sda = 1'b0;
                    s.rel = 1'b1;
                    frame = 1'b0;
                end
                PH_ACK_HIGH:  begin s.scl = 1'b1; frame = 1'b0; end
                PH_ACK_LOW:   begin s.scl = 1'b0; frame = 1'b0; end
                PH_ACK_DRIVE: begin s.rel = 1'b0; frame = 1'b0; end
                PH_RD_HIGH:   begin s.rel = 1'b1; s.scl = 1'b1; end
                PH_RD_HOLD: begin
                    s.shreg   = {s.shreg[6:0], i_sda};
                    s.bit_cnt = s.bit_cnt + 4'd1;
                    if (s.bit_cnt >= 4'd8) s.rx = s.shreg;
                end
                PH_RD_LOW:   s.scl = 1'b0;
                PH_NK_DRIVE: s.rel = 1'b0;
                PH_NK_SDA:   s.sda = 1'b1;
                PH_NK_HIGH:  s.scl = 1'b1;
                PH_NK_LOW:   s.scl = 1'b0;
                PH_SP_HIGH:  begin s.sda = 1'b0; s.rel = 1'b0; s.scl = 1'b1; end
                PH_SP_SDA:   s.sda = 1'b1;
                default:     ;
            endcase
            s.dly = load_ticks(frame ? i_frame_ticks : i_byte_ticks);
        end

        o_state = s;
    end

endmodule

@@ design/i2c_eeprom_byte_access_master.sv @@
// Top level of the I2C EEPROM byte access master: input register, sequencer
// state, configuration registers and result register. Uses i2cee_pkg, i2cee_step.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ------------------------------------
//  in        sink       i_in_valid / o_in_ready   kind, request operands, sda_in
//  out       source     o_out_valid / i_out_ready scl, sda, release, busy, done,
//                                                 read_byte, rejected
//  cfg       sink       i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
//  Each beat passes from acceptance into the input register, then through
//  the sequencer step into the result register.
//  One beat is accepted every cycle while the result side keeps taking beats.
//  Reset (i_rst_n low, synchronous) empties both registers, returns the
//  sequencer to idle with SCL and SDA high and driven, and loads the phase
//  lengths 10 and 20. A stall on the out channel holds the result register,
//  and then the input register, while the input side can still fill the
//  input register once.

module i2c_eeprom_byte_access_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // input beats
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [6:0] i_dev_addr,
    input  logic [7:0] i_addr_high,
    input  logic [7:0] i_addr_low,
    input  logic [7:0] i_write_value,
    input  logic [6:0] i_rd_dev_addr,
    input  logic       i_sda_in,
    // result beats
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_sda_released,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_read_byte,
    output logic       o_rejected
);
    import i2cee_pkg::*;

    // configuration registers
    logic [7:0] r_byte_ticks;
    logic [7:0] r_frame_ticks;

    // input register
    logic       r_in_vld;
    logic [1:0] r_kind;
    t_req       r_req;
    logic       r_sda;

    // sequencer state and its next value
    t_state     r_state;
    t_state     n_state;
    t_flags     n_flags;

    // result register
    logic       r_out_vld;

    logic       adv;

    // Process the held beat when the result register is free or draining
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_ticks  <= BYTE_TICKS_RST;
            r_frame_ticks <= FRAME_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BYTE_TICKS:  r_byte_ticks  <= i_cfg_data;
                REG_FRAME_TICKS: r_frame_ticks <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // Input register: capture a beat whenever the slot is free or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind                 <= i_kind;
            r_req.is_read          <= (i_kind == KIND_READ);
            r_req.dev_addr         <= i_dev_addr;
            r_req.addr_high        <= i_addr_high;
            r_req.addr_low         <= i_addr_low;
            r_req.write_value      <= i_write_value;
            r_req.rd_dev_addr      <= i_rd_dev_addr;
            r_sda                  <= i_sda_in;
        end
    end

    i2cee_step u_step (
        .i_state       (r_state),
        .i_req         (r_req),
        .i_kind        (r_kind),
        .i_sda         (r_sda),
        .i_byte_ticks  (r_byte_ticks),
        .i_frame_ticks (r_frame_ticks),
        .o_state       (n_state),
        .o_flags       (n_flags)
    );

    // Sequencer state: advance once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, scl: 1'b1, sda: 1'b1, rel: 1'b0, default: '0};
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_scl_level    <= n_state.scl;
            o_sda_level    <= n_state.sda;
            o_sda_released <= n_state.rel;
            o_busy_res     <= (n_state.phase != PH_IDLE);
            o_done_res     <= n_flags.done;
            o_read_byte    <= n_state.rx;
            o_rejected     <= n_flags.rejected;
        end
    end

    assign o_out_valid = r_out_vld;

    // A running phase always has time left; idle holds a cleared timer
    a_dly_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != PH_IDLE) |-> (r_state.dly != '0))
        else $error("phase timer empty while busy");

    a_dly_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_IDLE) |-> (r_state.dly == '0))
        else $error("phase timer running while idle");

    // Bus is left with SCL high and SDA driven between transactions
    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_IDLE) |-> (r_state.scl && !r_state.rel))
        else $error("bus not parked while idle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (!o_busy_res && !o_rejected))
        else $error("done reported with busy or rejected");

    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> o_busy_res)
        else $error("rejection while not busy");

endmodule
